// File: hdl/tga_rle_pkg.sv
package tga_rle_pkg;

  localparam int PIXEL_W = 32;
  localparam int COUNT_W = 8;
  localparam int COL_W   = 16;
  localparam int BPP_W   = 3;

  // packet phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_LIT    = 2'd2;

  localparam logic [7:0] RUN_FLAG = 8'h80;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd2;
  localparam int CFG_DATA_W = 16;

  localparam logic             RST_RLE_ENABLE      = 1'b1;
  localparam logic [BPP_W-1:0] RST_BYTES_PER_PIXEL = 3'd3;
  localparam logic [COL_W-1:0] RST_ROW_WIDTH       = 16'd640;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic             rle_enable;
    logic [BPP_W-1:0] bytes_per_pixel;
    logic [COL_W-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               row_end;
  } res_t;

endpackage

// File: hdl/tga_rle_front.sv
module tga_rle_front (
  input  logic                 clk,
  input  logic                 rst,
  input  tga_rle_pkg::cfg_t    cfg,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  output logic                 push,
  output tga_rle_pkg::res_t    res
);
  import tga_rle_pkg::*;

  logic [1:0]         phase, phase_next;
  logic [1:0]         byte_index, byte_index_next;
  logic [PIXEL_W-1:0] pixel_accumulator, acc_next;
  logic [COUNT_W-1:0] packet_remaining, rem_next;
  logic [COL_W-1:0]   column, column_next;

  logic [1:0]         last_idx;
  logic [COL_W-1:0]   width_eff;
  logic [COL_W-1:0]   left;
  logic               pix_done;
  logic               do_emit;
  logic [COUNT_W-1:0] emit_req;
  logic [COUNT_W-1:0] emit_cnt;
  logic               emit_end;
  logic [COL_W-1:0]   col_sum;
  logic [COUNT_W-1:0] hdr_n;
  logic [COUNT_W-1:0] rem_dec;

  always_comb begin
    if (cfg.bytes_per_pixel == 3'd0) begin
      last_idx = 2'd0;
    end else if (cfg.bytes_per_pixel > 3'd4) begin
      last_idx = 2'd3;
    end else begin
      last_idx = 2'(cfg.bytes_per_pixel - 3'd1);
    end
    width_eff = (cfg.row_width == '0) ? COL_W'(1) : cfg.row_width;
    left = (column < width_eff) ? width_eff - column : COL_W'(1);
  end

  // byte assembly, little-endian
  always_comb begin
    if (byte_index == 2'd0) begin
      acc_next = {24'd0, data_byte};
    end else begin
      acc_next = pixel_accumulator | (PIXEL_W'(data_byte) << {byte_index, 3'b000});
    end
    pix_done = (byte_index >= last_idx);
  end

  always_comb begin
    hdr_n = {1'b0, data_byte[6:0]} + COUNT_W'(1);
    if (COL_W'(hdr_n) > left) begin
      hdr_n = left[COUNT_W-1:0];
    end
    rem_dec = (packet_remaining != '0) ? packet_remaining - COUNT_W'(1) : packet_remaining;
  end

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    rem_next        = packet_remaining;
    do_emit         = 1'b0;
    emit_req        = COUNT_W'(1);
    if (!cfg.rle_enable) begin
      phase_next      = PH_HEADER;
      rem_next        = '0;
      byte_index_next = pix_done ? 2'd0 : byte_index + 2'd1;
      do_emit         = pix_done;
    end else begin
      unique case (phase)
        PH_RUN: begin
          byte_index_next = pix_done ? 2'd0 : byte_index + 2'd1;
          if (pix_done) begin
            phase_next = PH_HEADER;
            rem_next   = '0;
            do_emit    = 1'b1;
            emit_req   = packet_remaining;
          end
        end
        PH_LIT: begin
          byte_index_next = pix_done ? 2'd0 : byte_index + 2'd1;
          if (pix_done) begin
            rem_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = PH_HEADER;
            end
            do_emit = 1'b1;
          end
        end
        default: begin
          rem_next        = hdr_n;
          byte_index_next = 2'd0;
          phase_next      = ((data_byte & RUN_FLAG) != '0) ? PH_RUN : PH_LIT;
        end
      endcase
    end
  end

  // clamp the emitted count to the row and advance the column
  always_comb begin
    emit_cnt = emit_req;
    if (COL_W'(emit_req) > left) begin
      emit_cnt = left[COUNT_W-1:0];
    end
    if (emit_cnt == '0) begin
      emit_cnt = COUNT_W'(1);
    end
    emit_end = (COL_W'(emit_cnt) >= left);
    col_sum  = column + COL_W'(emit_cnt);
    column_next = column;
    if (do_emit) begin
      if (emit_end || col_sum >= width_eff) begin
        column_next = '0;
      end else begin
        column_next = col_sum;
      end
    end
  end

  logic hdr_step;
  assign hdr_step = cfg.rle_enable && phase != PH_RUN && phase != PH_LIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_index        <= 2'd0;
      pixel_accumulator <= '0;
      packet_remaining  <= '0;
      column            <= '0;
    end else if (take) begin
      column     <= column_next;
      byte_index <= byte_index_next;
      if (!hdr_step) begin
        pixel_accumulator <= acc_next;
      end
      if (do_emit && emit_end) begin
        phase            <= PH_HEADER;
        packet_remaining <= '0;
      end else begin
        phase            <= phase_next;
        packet_remaining <= rem_next;
      end
    end
  end

  assign push             = take && do_emit;
  assign res.pixel_value  = acc_next;
  assign res.repeat_count = emit_cnt;
  assign res.row_end      = emit_end;

endmodule

// File: hdl/tga_rle_queue.sv
module tga_rle_queue #(
  parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tga_rle_pkg::res_t  push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output tga_rle_pkg::res_t  head
);
  import tga_rle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/tga_rle_scanline_decoder.sv
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_valid/cfg_ready   cfg_index[1:0], cfg_data[15:0]
// in       in         in_valid/in_stall     data_byte[7:0]
// out      out        out_valid/out_stall   pixel_value[31:0], repeat_count[7:0], row_end
//
// One byte per clock while in_stall is low; each completed pixel is registered
// into the result queue. The decoder state advances in the cycle a byte is taken.
// A result queue (QUEUE_DEPTH entries) sits between decoder and output; in_stall
// rises only while that queue is full. Synchronous reset clears the decoder,
// the queue and loads the register defaults. cfg_ready is always high.
module tga_rle_scanline_decoder #(
  parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tga_rle_pkg::PIXEL_W-1:0]    pixel_value,
  output logic [tga_rle_pkg::COUNT_W-1:0]    repeat_count,
  output logic                               row_end
);
  import tga_rle_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t head;
  logic take;
  logic push;
  logic full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle_enable      <= RST_RLE_ENABLE;
      cfg.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
      cfg.row_width       <= RST_ROW_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RLE_ENABLE:      cfg.rle_enable      <= cfg_data[0];
        CFG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_ROW_WIDTH:       cfg.row_width       <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  tga_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (data_byte),
    .push      (push),
    .res       (res)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign pixel_value  = head.pixel_value;
  assign repeat_count = head.repeat_count;
  assign row_end      = head.row_end;

endmodule
